### hw/rtl/aiks_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aiks_pkg
// Shared types, constants and AES helper functions for the key stretch block.
// ----------------------------------------------------------------------------
package aiks_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned BLOCK_W    = 128;
    localparam int unsigned KEY_W      = 256;
    localparam int unsigned AES_ROUNDS = 14;
    localparam int unsigned NUM_LANES  = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CNT_W      = 64;
    localparam int unsigned RND_W      = 4;
    localparam logic [CNT_W-1:0] ROUND_COUNT_RST = 64'd6000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROUND_COUNT = 3'd0,
        REG_SEED_WORD0  = 3'd1,
        REG_SEED_WORD1  = 3'd2,
        REG_SEED_WORD2  = 3'd3,
        REG_SEED_WORD3  = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYGEN,
        ST_RUN,
        ST_DONE
    } t_state;

    // control from the sequencer to each lane
    typedef struct packed {
        logic             load;   // take a new block
        logic             first;  // apply initial round key xor
        logic             step;   // run one round
        logic             last;   // final round, no mix columns
    } t_lane_ctrl;

    typedef logic [BLOCK_W-1:0] t_block;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte i of the block sits at bits [127-8i -: 8]
    function automatic t_block aes_round(input t_block s, input t_block rk,
                                         input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        t_block     o;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4*c] = SBOX[s[127 - 8*(i + 4*((c + i) % 4)) -: 8]];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[127 - 8*i -: 8] = t[i];
        end
        return o ^ rk;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/aiks_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aiks_if
// Valid/ready channel carrying four 64-bit words.
// ----------------------------------------------------------------------------
interface aiks_if;
    logic        valid;
    logic        ready;
    logic [63:0] data0;
    logic [63:0] data1;
    logic [63:0] data2;
    logic [63:0] data3;

    modport source (output valid, output data0, output data1, output data2,
                    output data3, input ready);
    modport sink   (input valid, input data0, input data1, input data2,
                    input data3, output ready);
endinterface
`default_nettype wire

### hw/rtl/aiks_keysched.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aiks_keysched
// AES-256 key expansion, one round key per cycle into a 15-entry store.
// ----------------------------------------------------------------------------
module aiks_keysched (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [aiks_pkg::KEY_W-1:0] i_key,
    input  wire logic [aiks_pkg::RND_W-1:0] i_rd_idx,
    output logic      [aiks_pkg::BLOCK_W-1:0] o_rk,
    output logic                        o_busy
);
    import aiks_pkg::*;

    logic [BLOCK_W-1:0] r_rk [AES_ROUNDS+1];
    logic [255:0]       r_win;      // last eight words, w[i-8]..w[i-1]
    logic [7:0]         r_rcon;
    logic [RND_W-1:0]   r_idx;      // round key being produced
    logic               r_busy;
    logic [31:0]        n_wa, n_wb, n_wc, n_wd;
    logic [BLOCK_W-1:0] n_rk;

    // each step makes four words; even steps use rot/sub/rcon, odd ones sub
    always_comb begin
        logic [31:0] t;
        t = r_win[31:0];
        if (!r_idx[0]) begin
            t = sub_word({t[23:0], t[31:24]}) ^ {r_rcon, 24'h0};
        end else begin
            t = sub_word(t);
        end
        n_wa = r_win[255:224] ^ t;
        n_wb = r_win[223:192] ^ n_wa;
        n_wc = r_win[191:160] ^ n_wb;
        n_wd = r_win[159:128] ^ n_wc;
        n_rk = {n_wa, n_wb, n_wc, n_wd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= RND_W'(2);
        end else if (r_busy) begin
            r_idx  <= r_idx + 1'b1;
            if (r_idx == RND_W'(AES_ROUNDS)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_win  <= i_key;
            r_rcon <= 8'h01;
            r_rk[0] <= i_key[255:128];
            r_rk[1] <= i_key[127:0];
        end else if (r_busy) begin
            r_win <= {r_win[127:0], n_rk};
            r_rk[r_idx] <= n_rk;
            if (r_idx[0]) begin
                r_rcon <= xtime(r_rcon);
            end
        end
    end

    assign o_rk   = r_rk[i_rd_idx];
    assign o_busy = r_busy;

endmodule
`default_nettype wire

### hw/rtl/aiks_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aiks_lane
// One AES-256 round datapath with its state register.
// ----------------------------------------------------------------------------
module aiks_lane (
    input  wire logic                     i_clk,
    input  wire aiks_pkg::t_lane_ctrl     i_ctrl,
    input  wire logic [aiks_pkg::BLOCK_W-1:0] i_block,
    input  wire logic [aiks_pkg::BLOCK_W-1:0] i_rk,
    output logic      [aiks_pkg::BLOCK_W-1:0] o_block
);
    import aiks_pkg::*;

    t_block r_state;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_state <= i_block;
        end else if (i_ctrl.first) begin
            r_state <= r_state ^ i_rk;
        end else if (i_ctrl.step) begin
            r_state <= aes_round(r_state, i_rk, i_ctrl.last);
        end
    end

    assign o_block = r_state;

endmodule
`default_nettype wire

### hw/rtl/aes256_iterated_key_stretch_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes256_iterated_key_stretch_top
// Two-lane iterated AES-256 encryption of a 256-bit buffer.
// ----------------------------------------------------------------------------
// One item at a time. After acceptance the key schedule runs (start cycle, 13
// round keys and the handoff), then round_count encryption passes follow, each
// an initial key add plus 14 rounds, with both 128-bit halves in parallel lanes
// sharing a single round key read. A new transaction may be taken while the
// previous result waits in the output register; the block then holds in its
// done state until that result is handed off.
module aes256_iterated_key_stretch_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [aiks_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [aiks_pkg::WORD_W-1:0]   i_cfg_data,
    aiks_if.sink                               s_in,
    aiks_if.source                             m_out
);
    import aiks_pkg::*;

    logic [CNT_W-1:0]  r_round_count;
    logic [KEY_W-1:0]  r_seed;
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_iter;
    logic [RND_W-1:0]  r_rnd;
    logic              r_ks_start;
    logic              ks_busy;
    logic [BLOCK_W-1:0] rk;
    t_lane_ctrl        ctrl;
    logic [BLOCK_W-1:0] lane_in  [NUM_LANES];
    logic [BLOCK_W-1:0] lane_out [NUM_LANES];
    logic [4*WORD_W-1:0] r_out;
    logic [4*WORD_W-1:0] merged;
    logic              r_out_valid;
    logic              accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_count <= ROUND_COUNT_RST;
            r_seed        <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_ROUND_COUNT: r_round_count <= i_cfg_data;
                REG_SEED_WORD0:  r_seed[255:192] <= i_cfg_data;
                REG_SEED_WORD1:  r_seed[191:128] <= i_cfg_data;
                REG_SEED_WORD2:  r_seed[127:64]  <= i_cfg_data;
                REG_SEED_WORD3:  r_seed[63:0]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = s_in.valid && s_in.ready;
    assign s_in.ready = (r_state == ST_IDLE);

    aiks_keysched u_ks (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_ks_start),
        .i_key    (r_seed),
        .i_rd_idx (r_rnd),
        .o_rk     (rk),
        .o_busy   (ks_busy)
    );

    // input buffer layout: lane l takes words 2l and 2l+1
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        assign lane_in[l] = (l == 0) ? {s_in.data0, s_in.data1}
                                     : {s_in.data2, s_in.data3};
        aiks_lane u_lane (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_block (lane_in[l]),
            .i_rk    (rk),
            .o_block (lane_out[l])
        );
    end

    always_comb begin
        n_state    = r_state;
        ctrl.load  = accept;
        ctrl.first = 1'b0;
        ctrl.step  = 1'b0;
        ctrl.last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_KEYGEN;
                end
            end
            ST_KEYGEN: begin
                if (!ks_busy && !r_ks_start) begin
                    n_state = (r_iter == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                ctrl.first = (r_rnd == '0);
                ctrl.step  = (r_rnd != '0);
                ctrl.last  = (r_rnd == RND_W'(AES_ROUNDS));
                if (ctrl.last && r_iter == CNT_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ks_start <= 1'b0;
            r_rnd      <= '0;
            r_iter     <= '0;
        end else begin
            r_state    <= n_state;
            r_ks_start <= accept;
            if (accept) begin
                r_iter <= r_round_count;
                r_rnd  <= '0;
            end else if (r_state == ST_RUN) begin
                if (ctrl.last) begin
                    r_rnd  <= '0;
                    r_iter <= r_iter - 1'b1;
                end else begin
                    r_rnd <= r_rnd + 1'b1;
                end
            end
        end
    end

    // merge the lanes back into the four-word layout
    always_comb begin
        merged = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            merged[4*WORD_W-1 - l*BLOCK_W -: BLOCK_W] = lane_out[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && !r_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && !r_out_valid) begin
            r_out <= merged;
        end
    end

    assign m_out.valid = r_out_valid;
    assign m_out.data0 = r_out[255:192];
    assign m_out.data1 = r_out[191:128];
    assign m_out.data2 = r_out[127:64];
    assign m_out.data3 = r_out[63:0];

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_in.ready)
        else $error("input ready while busy");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> (m_out.valid && $stable(r_out)))
        else $error("result dropped while stalled");
    a_run_after_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !ks_busy)
        else $error("rounds started before key schedule done");
    a_run_has_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_iter != '0))
        else $error("rounds running with no passes left");
`endif

endmodule
`default_nettype wire
